>>> rtl/core/mcg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mcg_pkg;

    // Field widths.
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int WDAY_W  = 3;
    localparam int ROW_W   = 3;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TODAY_YEAR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TODAY_MONTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TODAY_DAY   = 2'd2;

    // Configuration reset values.
    localparam logic [YEAR_W-1:0]  TODAY_YEAR_RST  = 14'd2020;
    localparam logic [MONTH_W-1:0] TODAY_MONTH_RST = 4'd11;
    localparam logic [DAY_W-1:0]   TODAY_DAY_RST   = 5'd5;

    // Calendar constants.
    localparam logic [3:0] MON_JAN = 4'd1;
    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_MAR = 4'd3;
    localparam logic [3:0] MON_MAY = 4'd5;
    localparam logic [3:0] MON_JUN = 4'd6;
    localparam logic [3:0] MON_JUL = 4'd7;
    localparam logic [3:0] MON_AUG = 4'd8;
    localparam logic [3:0] MON_OCT = 4'd10;
    localparam logic [3:0] MON_DEC = 4'd12;
    localparam logic [3:0] MON_WRAP = 4'd12;
    localparam logic [WDAY_W-1:0] WDAY_SAT = 3'd6;

    // Year offset of one full Gregorian cycle and the Zeller bias (a multiple of 7).
    localparam int CYCLE_YEARS = 400;
    localparam int ZELLER_BIAS = 350;
    localparam int CENTURY     = 100;
    localparam int WEEK_DAYS   = 7;

    // Reciprocal constants: y / 100 = (y * 5243) >> 19 for y < 2^15,
    // s / 7 = (s * 2341) >> 14 for s < 1024.
    localparam int DIV100_MUL   = 5243;
    localparam int DIV100_SHIFT = 19;
    localparam int DIV7_MUL     = 2341;
    localparam int DIV7_SHIFT   = 14;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_REM,
        ST_SUM,
        ST_MOD,
        ST_EMIT
    } mcg_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div;
        logic rem;
        logic sum;
        logic mod;
        logic emit;
    } mcg_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic last_day;
    } mcg_stat_t;

    // The month term of Zeller's congruence, floor(13 * (m + 1) / 5).
    function automatic logic [5:0] zeller_month_term(input logic [3:0] m);
        logic [5:0] t;
        begin
            case (m)
                4'd0:    t = 6'd2;
                4'd1:    t = 6'd5;
                4'd2:    t = 6'd7;
                4'd3:    t = 6'd10;
                4'd4:    t = 6'd13;
                4'd5:    t = 6'd15;
                4'd6:    t = 6'd18;
                4'd7:    t = 6'd20;
                4'd8:    t = 6'd23;
                4'd9:    t = 6'd26;
                4'd10:   t = 6'd28;
                4'd11:   t = 6'd31;
                4'd12:   t = 6'd33;
                4'd13:   t = 6'd36;
                4'd14:   t = 6'd39;
                default: t = 6'd41;
            endcase
            return t;
        end
    endfunction

    // Days in a month; codes outside 1..12 count as 30-day months.
    function automatic logic [DAY_W-1:0] days_in_month(input logic [3:0] m,
                                                       input logic leap);
        logic [DAY_W-1:0] n;
        begin
            if (m == MON_FEB)
            begin
                n = leap ? 5'd29 : 5'd28;
            end
            else if (m == MON_JAN || m == MON_MAR || m == MON_MAY || m == MON_JUL ||
                     m == MON_AUG || m == MON_OCT || m == MON_DEC)
            begin
                n = 5'd31;
            end
            else
            begin
                n = 5'd30;
            end
            return n;
        end
    endfunction

    // Fixed holiday dates.
    function automatic logic is_holiday(input logic [3:0] m, input logic [DAY_W-1:0] d);
        begin
            return (m == MON_JAN && d == 5'd1) ||
                   (m == MON_MAR && d == 5'd8) ||
                   (m == MON_MAY && d >= 5'd1 && d <= 5'd4) ||
                   (m == MON_JUN && d == 5'd1) ||
                   (m == MON_JUL && d == 5'd1) ||
                   (m == MON_AUG && d == 5'd1) ||
                   (m == MON_OCT && d >= 5'd1 && d <= 5'd7);
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/mcg_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mcg_ctrl
    import mcg_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire mcg_stat_t stat,
    output mcg_cmd_t       cmd
);

    mcg_state_t state_reg;
    mcg_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands. Four setup steps, then one day per free output slot.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div    = 1'b1;
                state_next = ST_REM;
            end
            ST_REM:
            begin
                cmd.rem    = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                cmd.mod    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.last_day)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/mcg_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module mcg_datapath
    import mcg_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire mcg_cmd_t             cmd,
    output mcg_stat_t                 stat,
    input  wire logic [YEAR_W-1:0]    year,
    input  wire logic [MONTH_W-1:0]   month,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [YEAR_W-1:0]    cfg_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [DAY_W-1:0]          day,
    output logic [WDAY_W-1:0]         weekday,
    output logic [ROW_W-1:0]          row,
    output logic [DAY_W-1:0]          month_length,
    output logic                      is_today,
    output logic                      is_festival,
    output logic                      last
);

    // Configuration registers.
    logic [YEAR_W-1:0]  today_year_reg;
    logic [MONTH_W-1:0] today_month_reg;
    logic [DAY_W-1:0]   today_day_reg;

    // Setup registers.
    logic [YEAR_W-1:0]  year_reg;
    logic [MONTH_W-1:0] month_reg;
    logic [YEAR_W:0]    y_reg;
    logic [MONTH_W-1:0] m_reg;
    logic [7:0]         c_reg;
    logic [7:0]         c2_reg;
    logic [6:0]         yy_reg;
    logic [6:0]         rem2_reg;
    logic [9:0]         sum_reg;
    logic [DAY_W-1:0]   len_reg;

    // Day walk registers.
    logic [DAY_W-1:0]   cur_day_reg;
    logic [WDAY_W-1:0]  wd_reg;
    logic [ROW_W-1:0]   row_reg;

    // Output register.
    logic               out_valid_reg;
    logic [DAY_W-1:0]   day_reg;
    logic [WDAY_W-1:0]  weekday_reg;
    logic [ROW_W-1:0]   row_out_reg;
    logic [DAY_W-1:0]   len_out_reg;
    logic               is_today_reg;
    logic               is_festival_reg;
    logic               last_reg;

    logic               jan_feb;
    logic [YEAR_W:0]    y_next;
    logic [MONTH_W-1:0] m_next;
    logic [27:0]        c_prod;
    logic [26:0]        c2_prod;
    logic [YEAR_W:0]    yy_full;
    logic [YEAR_W-1:0]  rem2_full;
    logic               leap;
    logic [10:0]        sum_full;
    logic [21:0]        q7_prod;
    logic [6:0]         q7;
    logic [9:0]         wd_full;
    logic               day_is_today;

    // Zeller treats January and February as months 13 and 14 of the prior year.
    assign jan_feb = (month == MON_JAN) || (month == MON_FEB);
    assign y_next  = {1'b0, year} + (YEAR_W+1)'(CYCLE_YEARS) - (YEAR_W+1)'(jan_feb);
    assign m_next  = jan_feb ? month + MON_WRAP : month;

    // Divide by 100 through a reciprocal multiply.
    assign c_prod  = 28'(y_reg) * 28'(DIV100_MUL);
    assign c2_prod = 27'(year_reg) * 27'(DIV100_MUL);

    // Remainders after the century split.
    assign yy_full   = y_reg - (YEAR_W+1)'(c_reg) * (YEAR_W+1)'(CENTURY);
    assign rem2_full = year_reg - YEAR_W'(c2_reg) * YEAR_W'(CENTURY);

    // Gregorian leap rule: year % 400 == 0 is rem2 == 0 with the century a multiple of 4.
    assign leap = ((year_reg[1:0] == 2'd0) && (rem2_reg != 7'd0)) ||
                  ((rem2_reg == 7'd0) && (c2_reg[1:0] == 2'd0));

    // Zeller sum before the modulo; the bias keeps it positive.
    assign sum_full = 11'(ZELLER_BIAS) + 11'(c_reg[7:2]) + 11'(yy_reg) + 11'(yy_reg[6:2])
                    + 11'(zeller_month_term(m_reg)) - {2'b00, c_reg, 1'b0};

    // Modulo 7 through a reciprocal multiply and one subtract.
    assign q7_prod = 22'(sum_reg) * 22'(DIV7_MUL);
    assign q7      = q7_prod[DIV7_SHIFT +: 7];
    assign wd_full = sum_reg - 10'(q7) * 10'(WEEK_DAYS);

    assign day_is_today = (year_reg == today_year_reg) && (month_reg == today_month_reg) &&
                          (cur_day_reg == today_day_reg);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            today_year_reg  <= TODAY_YEAR_RST;
            today_month_reg <= TODAY_MONTH_RST;
            today_day_reg   <= TODAY_DAY_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TODAY_YEAR:  today_year_reg  <= cfg_data;
                CFG_TODAY_MONTH: today_month_reg <= cfg_data[MONTH_W-1:0];
                CFG_TODAY_DAY:   today_day_reg   <= cfg_data[DAY_W-1:0];
                default:         ;
            endcase
        end
    end

    // Setup steps and the day walk.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            year_reg  <= year;
            month_reg <= month;
            y_reg     <= y_next;
            m_reg     <= m_next;
        end
        if (cmd.div)
        begin
            c_reg  <= c_prod[DIV100_SHIFT +: 8];
            c2_reg <= c2_prod[DIV100_SHIFT +: 8];
        end
        if (cmd.rem)
        begin
            yy_reg   <= yy_full[6:0];
            rem2_reg <= rem2_full[6:0];
        end
        if (cmd.sum)
        begin
            sum_reg <= sum_full[9:0];
            len_reg <= days_in_month(month_reg, leap);
        end
        if (cmd.mod)
        begin
            wd_reg      <= wd_full[WDAY_W-1:0];
            cur_day_reg <= DAY_W'(1);
            row_reg     <= '0;
        end
        else if (cmd.emit)
        begin
            cur_day_reg <= cur_day_reg + DAY_W'(1);
            wd_reg      <= (wd_reg == WDAY_SAT) ? '0 : wd_reg + WDAY_W'(1);
            row_reg     <= row_reg + ROW_W'(wd_reg == WDAY_SAT);
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            day_reg         <= cur_day_reg;
            weekday_reg     <= wd_reg;
            row_out_reg     <= row_reg;
            len_out_reg     <= len_reg;
            is_today_reg    <= day_is_today;
            is_festival_reg <= is_holiday(month_reg, cur_day_reg);
            last_reg        <= (cur_day_reg == len_reg);
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign stat.last_day = (cur_day_reg == len_reg);

    assign out_valid    = out_valid_reg;
    assign day          = day_reg;
    assign weekday      = weekday_reg;
    assign row          = row_out_reg;
    assign month_length = len_out_reg;
    assign is_today     = is_today_reg;
    assign is_festival  = is_festival_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

>>> rtl/core/month_calendar_grid_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Month calendar grid.
// The input channel (in_valid/in_ready) takes one item: a year and a month.
// The output channel (out_valid/out_ready) returns one item per day of that
// month, day 1 first, with weekday column, grid row, month length and the
// is_today, is_festival and last flags; last marks the final day.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// today_year (0), today_month (1) and today_day (2); it is always ready.
// It must be written only while no month is in progress; the block itself
// does not enforce this. After an input item is accepted, four registered
// setup steps (divide by 100, remainders, Zeller sum, modulo 7) run in turn,
// then the day sequencer fills the output register.
// Throughput: one day per cycle while out_ready stays high; the next item
// is taken only after the final day of the month has been emitted.
// in_ready is high only while the controller is idle; the next item is taken
// while the final day still waits in the output register.
// When the receiver stalls, the day walk holds and the output item holds.
// Reset clears the controller and output valid and restores the
// configuration registers to 2020-11-05.
module month_calendar_grid_top
    import mcg_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [YEAR_W-1:0]    year,
    input  wire logic [MONTH_W-1:0]   month,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [YEAR_W-1:0]    cfg_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [DAY_W-1:0]          day,
    output logic [WDAY_W-1:0]         weekday,
    output logic [ROW_W-1:0]          row,
    output logic [DAY_W-1:0]          month_length,
    output logic                      is_today,
    output logic                      is_festival,
    output logic                      last
);

    mcg_cmd_t  cmd;
    mcg_stat_t stat;

    // Configuration writes are taken at any time.
    assign cfg_ready = 1'b1;

    // Sequencer.
    mcg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Arithmetic, day walk and output register.
    mcg_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .year         (year),
        .month        (month),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .day          (day),
        .weekday      (weekday),
        .row          (row),
        .month_length (month_length),
        .is_today     (is_today),
        .is_festival  (is_festival),
        .last         (last)
    );

endmodule

`default_nettype wire

>>> rtl/core/mcg_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mcg_checker
    import mcg_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_valid,
    input wire logic                 in_ready,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire logic [DAY_W-1:0]     day,
    input wire logic [DAY_W-1:0]     month_length,
    input wire logic                 last
);

    // A stalled item holds its day.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(day))
        else $error("output item changed while stalled");

    // Only one month is in progress at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again while a month is in progress");

    // Days follow one another with no gap once a non-final day is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid && (day == $past(day) + 5'd1))
        else $error("day sequence broken");

    // The last flag marks exactly the day equal to the month length.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((day == month_length) == last))
        else $error("last flag disagrees with month length");

    // No new month is taken before the final day has been produced.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
        else $error("input ready in the middle of a month");

endmodule

bind month_calendar_grid_top mcg_checker u_mcg_checker (.*);

`default_nettype wire

>>> tb/sv/month_calendar_grid_top_tb.sv
`timescale 1ns / 1ps

module month_calendar_grid_top_tb;
    import mcg_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    // Index 3 addresses no register; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

    // One expected day cell of the month grid.
    typedef struct packed {
        logic [DAY_W-1:0]  day;
        logic [WDAY_W-1:0] wday;
        logic [ROW_W-1:0]  row;
        logic [DAY_W-1:0]  len;
        logic              today;
        logic              holiday;
        logic              final_day;
    } day_cell_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [YEAR_W-1:0]    year = '0;
    logic [MONTH_W-1:0]   month = '0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [YEAR_W-1:0]    cfg_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [DAY_W-1:0]     day;
    logic [WDAY_W-1:0]    weekday;
    logic [ROW_W-1:0]     row;
    logic [DAY_W-1:0]     month_length;
    logic                 is_today;
    logic                 is_festival;
    logic                 last;

    // Mirror of the highlighted date registers.
    logic [YEAR_W-1:0]    mark_year = TODAY_YEAR_RST;
    logic [MONTH_W-1:0]   mark_month = TODAY_MONTH_RST;
    logic [DAY_W-1:0]     mark_day = TODAY_DAY_RST;

    day_cell_t expected_days[$];
    int        mismatches = 0;
    int        cycle_count = 0;
    bit        rx_stalls = 1'b1;
    int        rx_hold_req = 0;

    month_calendar_grid_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .year         (year),
        .month        (month),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .day          (day),
        .weekday      (weekday),
        .row          (row),
        .month_length (month_length),
        .is_today     (is_today),
        .is_festival  (is_festival),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The run is stopped if it hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t ns: timeout after %0d cycles, %0d day items outstanding",
                     $time, cycle_count, expected_days.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Fixed holiday dates.
    function automatic bit holiday_date(input int mm, input int dd);
        return (mm == MON_JAN && dd == 1) ||
               (mm == MON_MAR && dd == 8) ||
               (mm == MON_MAY && dd >= 1 && dd <= 4) ||
               (mm == MON_JUN && dd == 1) ||
               (mm == MON_JUL && dd == 1) ||
               (mm == MON_AUG && dd == 1) ||
               (mm == MON_OCT && dd >= 1 && dd <= 7);
    endfunction

    // Lays out the whole month and queues one expected entry per day.
    task automatic predict_month_days(input logic [YEAR_W-1:0] y,
                                      input logic [MONTH_W-1:0] m);
        int        len;
        int        zy;
        int        zm;
        int        cent;
        int        yrs;
        int        wd;
        int        rw;
        bit        leap;
        day_cell_t entry;
        leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        case (m)
            MON_FEB: len = leap ? 29 : 28;
            MON_JAN, MON_MAR, MON_MAY, MON_JUL, MON_AUG, MON_OCT, MON_DEC: len = 31;
            default: len = 30;
        endcase

        // Zeller's congruence for day 1, shifted by one 400-year cycle so that
        // year zero needs no wrap; January and February belong to the prior year.
        zy = int'(y) + 400;
        zm = int'(m);
        if (m == MON_JAN || m == MON_FEB)
        begin
            zy = zy - 1;
            zm = zm + 12;
        end
        cent = zy / 100;
        yrs = zy - cent * 100;
        wd = (350 + cent / 4 + yrs + yrs / 4 + (13 * (zm + 1)) / 5 - 2 * cent) % 7;

        rw = 0;
        for (int d = 1; d <= len; d++)
        begin
            entry.day = DAY_W'(d);
            entry.wday = WDAY_W'(wd);
            entry.row = ROW_W'(rw);
            entry.len = DAY_W'(len);
            entry.today = (y == mark_year) && (m == mark_month) && (d == int'(mark_day));
            entry.holiday = holiday_date(int'(m), d);
            entry.final_day = (d == len);
            expected_days.push_back(entry);
            if (wd == int'(WDAY_SAT))
                rw = rw + 1;
            wd = (wd + 1) % 7;
        end
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    // Each day item that leaves the block is compared with the oldest expectation.
    always @(posedge clk)
    begin : day_checker
        day_cell_t want;
        if (out_valid && out_ready)
        begin
            if (expected_days.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: unexpected day item, expected none, actual day %0d",
                         $time, day);
            end
            else
            begin
                want = expected_days.pop_front();
                check_field("day", int'(want.day), int'(day));
                check_field("weekday", int'(want.wday), int'(weekday));
                check_field("row", int'(want.row), int'(row));
                check_field("month_length", int'(want.len), int'(month_length));
                check_field("is_today", int'(want.today), int'(is_today));
                check_field("is_festival", int'(want.holiday), int'(is_festival));
                check_field("last", int'(want.final_day), int'(last));
            end
        end
    end

    // Receiver: always ready, or ready and stall runs of random length; a long hold on request.
    initial
    begin : day_receiver
        int  hold_left;
        int  run_left;
        bit  run_ready;
        hold_left = 0;
        run_left = 0;
        run_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req > 0)
            begin
                hold_left = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!rx_stalls)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                if (run_left == 0)
                begin
                    run_ready = !run_ready;
                    run_left = run_ready ? $urandom_range(1, 12) : $urandom_range(1, 6);
                end
                run_left--;
                out_ready <= run_ready;
            end
        end
    end

    // Offers one month item and waits until it is taken; valid stays high.
    task automatic send_month(input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] m);
        in_valid <= 1'b1;
        year <= y;
        month <= m;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_month_days(y, m);
    endtask

    task automatic idle_gap(input int cycles);
        if (cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Waits until every expected day has come out and the block is idle again.
    task automatic wait_months_done;
        @(posedge clk);
        while (expected_days.size() != 0 || !in_ready)
            @(posedge clk);
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [YEAR_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_TODAY_YEAR:  mark_year = data;
            CFG_TODAY_MONTH: mark_month = data[MONTH_W-1:0];
            CFG_TODAY_DAY:   mark_day = data[DAY_W-1:0];
            default:         ;
        endcase
    endtask

    task automatic set_today(input logic [YEAR_W-1:0] y, input logic [YEAR_W-1:0] m,
                             input logic [YEAR_W-1:0] d);
        write_reg(CFG_TODAY_YEAR, y);
        write_reg(CFG_TODAY_MONTH, m);
        write_reg(CFG_TODAY_DAY, d);
        cfg_valid <= 1'b0;
    endtask

    // Reset date, every month length and festival, leap rules, year zero,
    // the largest year and the month codes outside 1..12.
    task automatic test_directed_months;
        int ys[$] = '{2020, 2021, 2021, 2021, 2021, 2021, 2021, 2021, 2021, 2021, 2020,
                      9999, 2000, 1900, 2024, 0, 0, 16383, 1, 5000, 123};
        int ms[$] = '{11, 1, 2, 3, 4, 5, 6, 7, 9, 10, 8,
                      12, 2, 2, 2, 1, 2, 15, 0, 13, 14};
        rx_stalls = 1'b1;
        for (int k = 0; k < ys.size(); k++)
        begin
            send_month(YEAR_W'(ys[k]), MONTH_W'(ms[k]));
            if (k < ys.size() - 1)
                idle_gap($urandom_range(0, 3));
        end
        in_valid <= 1'b0;
        wait_months_done;
    endtask

    // Highlighted date at its extremes and out of range; one write to no register.
    task automatic test_register_extremes;
        set_today(14'd1, 14'd1, 14'd1);
        send_month(14'd1, MON_JAN);
        in_valid <= 1'b0;
        wait_months_done;

        set_today(14'd9999, 14'd12, 14'd31);
        send_month(14'd9999, MON_DEC);
        in_valid <= 1'b0;
        wait_months_done;

        write_reg(CFG_NO_REG, 14'h3FFF);
        set_today(14'h3FFF, 14'h3FFF, 14'h3FFF);
        send_month(14'h3FFF, 4'd15);
        in_valid <= 1'b0;
        wait_months_done;

        set_today(14'd0, 14'd0, 14'd0);
        send_month(14'd0, MON_JAN);
        in_valid <= 1'b0;
        wait_months_done;
    endtask

    // The receiver holds off long enough that the block stalls its input.
    task automatic test_output_backpressure;
        set_today(YEAR_W'($urandom_range(1, 9999)), YEAR_W'($urandom_range(1, 12)),
                  YEAR_W'($urandom_range(1, 31)));
        rx_hold_req = 300;
        for (int k = 0; k < 5; k++)
            send_month(YEAR_W'($urandom_range(1, 9999)), MONTH_W'($urandom_range(1, 12)));
        in_valid <= 1'b0;
        wait_months_done;
    endtask

    // Random months in bursts; many hit the highlighted month or a century February.
    task automatic send_random_months(input int count, input int max_gap);
        int                 burst;
        int                 pick;
        logic [YEAR_W-1:0]  y;
        logic [MONTH_W-1:0] m;
        burst = $urandom_range(1, 8);
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                y = mark_year;
                m = mark_month;
            end
            else if (pick < 42)
            begin
                y = YEAR_W'($urandom_range(0, 16383));
                m = MONTH_W'($urandom_range(0, 15));
            end
            else if (pick < 55)
            begin
                y = YEAR_W'(100 * $urandom_range(0, 99));
                m = MON_FEB;
            end
            else
            begin
                y = YEAR_W'($urandom_range(1, 9999));
                m = MONTH_W'($urandom_range(1, 12));
            end
            send_month(y, m);
            burst--;
            if (burst == 0 && k < count - 1)
            begin
                idle_gap($urandom_range(0, max_gap));
                burst = $urandom_range(1, 8);
            end
        end
        in_valid <= 1'b0;
    endtask

    task automatic test_random_traffic;
        // Back to back with an always-ready receiver.
        rx_stalls = 1'b0;
        set_today(YEAR_W'($urandom_range(1, 9999)), YEAR_W'($urandom_range(1, 12)),
                  YEAR_W'($urandom_range(1, 31)));
        send_random_months(35, 0);
        wait_months_done;

        // Long sender gaps against a stalling receiver.
        rx_stalls = 1'b1;
        set_today(YEAR_W'($urandom_range(1, 9999)), YEAR_W'($urandom_range(1, 12)),
                  YEAR_W'($urandom_range(1, 31)));
        send_random_months(40, 40);
        wait_months_done;

        // Full-width register data, short gaps.
        set_today(YEAR_W'($urandom_range(0, 16383)), YEAR_W'($urandom_range(0, 16383)),
                  YEAR_W'($urandom_range(0, 16383)));
        send_random_months(40, 6);
        wait_months_done;

        rx_stalls = 1'b0;
        set_today(YEAR_W'($urandom_range(1, 9999)), YEAR_W'($urandom_range(1, 12)),
                  YEAR_W'($urandom_range(1, 31)));
        send_random_months(30, 20);
        wait_months_done;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_months;
        test_register_extremes;
        test_output_backpressure;
        test_random_traffic;

        wait_months_done;
        repeat (40) @(posedge clk);
        if (expected_days.size() != 0)
        begin
            mismatches++;
            $display("%0t ns: %0d expected day items never arrived", $time, expected_days.size());
        end
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> month_calendar_grid_top.f
rtl/core/mcg_pkg.sv
rtl/core/mcg_ctrl.sv
rtl/core/mcg_datapath.sv
rtl/core/month_calendar_grid_top.sv
rtl/core/mcg_checker.sv
tb/sv/month_calendar_grid_top_tb.sv
